// ----- hw/rtl/rti_pkg.sv -----
// Shared constants for the ray/triangle intersection block.
// No dependencies; used by ray_triangle_intersect and rti_div.
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int PKT_W          = 48;
	localparam int OUT_FRAC       = 16;
	localparam int QUOT_BITS      = 31;
	localparam int DIST_W         = 31;
	localparam int BARY_W         = 18;
	localparam int EPS_W          = 8;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	localparam logic [BARY_W-1:0] BARY_CAP = 18'd131072;
	localparam logic [BARY_W-1:0] BARY_MAX = 18'd131071;
	localparam int                ONE_Q16  = 65536;

	// register index, taken from paddr[2]
	localparam logic REG_CULL = 1'b0;
	localparam logic REG_EPS  = 1'b1;
endpackage
`default_nettype wire

// ----- hw/rtl/rti_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Uses rti_pkg for the default quotient width.
`timescale 1ns / 1ps
`default_nettype none
module rti_div #(
	parameter int NUM_W = 76,
	parameter int DEN_W = 60,
	parameter int QB    = rti_pkg::QUOT_BITS
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QB-1:0]    quot,
	output logic                  ovf
);
	localparam int CW = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;

	logic [CW-1:0]    rem_s  [QB];
	logic [DEN_W-1:0] den_s  [QB];
	logic [QB-1:0]    quot_s [QB];
	logic             ovf_s  [QB];

	logic [CW-1:0]    cur_r  [QB];
	logic [DEN_W-1:0] cur_d  [QB];
	logic [QB-1:0]    cur_q  [QB];
	logic             cur_o  [QB];
	logic [CW:0]      diff   [QB];
	logic             ovf_in;

	// quotient does not fit in QB bits
	assign ovf_in = (CW'(num) >= (CW'(den) << QB));

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			if (k == 0) begin
				cur_r[k] = CW'(num);
				cur_d[k] = den;
				cur_q[k] = '0;
				cur_o[k] = ovf_in;
			end else begin
				cur_r[k] = rem_s[k-1];
				cur_d[k] = den_s[k-1];
				cur_q[k] = quot_s[k-1];
				cur_o[k] = ovf_s[k-1];
			end
			diff[k] = {1'b0, cur_r[k]} - {1'b0, (CW'(cur_d[k]) << (QB - 1 - k))};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				rem_s[k]  <= diff[k][CW] ? cur_r[k] : diff[k][CW-1:0];
				quot_s[k] <= cur_q[k] | (QB'(!diff[k][CW]) << (QB - 1 - k));
				den_s[k]  <= cur_d[k];
				ovf_s[k]  <= cur_o[k];
			end
		end
	end

	assign quot = quot_s[QB-1];
	assign ovf  = ovf_s[QB-1];
endmodule
`default_nettype wire

// ----- hw/rtl/ray_triangle_intersect.sv -----
// Ray/triangle intersection top level: front end, three dividers, back end.
// Depends on rti_pkg and rti_div.
`timescale 1ns / 1ps
`default_nettype none
// Moller-Trumbore ray/triangle test. One test is taken per cycle while tri_stall
// is low; each result passes through 6 stages of edge, cross product and dot
// product math, 31 stages of the bit-per-stage dividers for u, v and t, and
// 3 stages of range checks and hit point math. A one-entry skid buffer sits at
// the output: when res_stall is held with a valid result, the pipeline moves
// once more and freezes as tri_stall rises. On a miss all result fields
// are zero. Registers: 0x0 cull_backfaces, 0x4 epsilon_lsb; write only when idle.
module ray_triangle_intersect #(
	parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rti_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [rti_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [rti_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	input  wire logic                            tri_valid,
	output logic                                 tri_stall,
	input  wire logic [rti_pkg::PKT_W-1:0]       vertex_a,
	input  wire logic [rti_pkg::PKT_W-1:0]       vertex_b,
	input  wire logic [rti_pkg::PKT_W-1:0]       vertex_c,
	input  wire logic [rti_pkg::PKT_W-1:0]       ray_origin,
	input  wire logic [rti_pkg::PKT_W-1:0]       ray_direction,
	input  wire logic [rti_pkg::PKT_W-1:0]       face_normal,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic                                 hit,
	output logic      [rti_pkg::DIST_W-1:0]      distance,
	output logic signed [rti_pkg::BARY_W-1:0]    bary_u,
	output logic signed [rti_pkg::BARY_W-1:0]    bary_v,
	output logic      [rti_pkg::PKT_W-1:0]       hit_point
);
	import rti_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int WW   = (3 * C > PKT_W) ? 3 * C : PKT_W;
	localparam int DW   = C + 1;
	localparam int PWW  = 2 * C + 2;
	localparam int QWW  = 2 * C + 3;
	localparam int MW   = 3 * C + 4;
	localparam int NW   = 3 * C + 6;
	localparam int NUMW = NW + OUT_FRAC;
	localparam int QB   = QUOT_BITS;
	localparam int CHK  = BARY_W + 3;
	localparam int HPW  = C + QB + 1;
	localparam int SW   = C + QB + 1 - OUT_FRAC;

	typedef struct packed {
		logic            miss;
		logic            neg_u;
		logic            neg_v;
		logic            neg_t;
		logic [2:0][C-1:0] d;
		logic [2:0][C-1:0] o;
	} side_t;

	function automatic logic signed [C-1:0] coord(input logic [PKT_W-1:0] w, input int k);
		logic [WW-1:0] x;
		x = WW'(w);
		return x[k*C +: C];
	endfunction

	// configuration
	logic             cull_q;
	logic [EPS_W-1:0] eps_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_q <= 1'b0;
			eps_q  <= EPS_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_CULL: cull_q <= pwdata[0];
				REG_EPS:  eps_q  <= pwdata[EPS_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CULL: prdata = APB_DATA_W'(cull_q);
			REG_EPS:  prdata = APB_DATA_W'(eps_q);
			default:  prdata = '0;
		endcase
	end

	// pipeline advance: frozen only while the skid holds a result
	logic skid_full_q;
	logic en;
	assign en        = !skid_full_q;
	assign tri_stall = skid_full_q;

	// S1: unpack, edges, cull products
	logic signed [C-1:0] a_c [3], b_c [3], c_c [3], o_c [3], d_c [3], n_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_c[k] = coord(vertex_a, k);
			b_c[k] = coord(vertex_b, k);
			c_c[k] = coord(vertex_c, k);
			o_c[k] = coord(ray_origin, k);
			d_c[k] = coord(ray_direction, k);
			n_c[k] = coord(face_normal, k);
		end
	end

	logic                  v_s1;
	logic signed [DW-1:0]  e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [C-1:0]   d_s1 [3], o_s1 [3];
	logic signed [2*C-1:0] dn_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e1_s1[k] <= DW'(b_c[k]) - DW'(a_c[k]);
				e2_s1[k] <= DW'(c_c[k]) - DW'(a_c[k]);
				s_s1[k]  <= DW'(o_c[k]) - DW'(a_c[k]);
				d_s1[k]  <= d_c[k];
				o_s1[k]  <= o_c[k];
				dn_s1[k] <= (2*C)'(d_c[k]) * (2*C)'(n_c[k]);
			end
		end
	end

	// S2: cross product terms, cull decision
	logic                  v_s2, cull_s2;
	logic signed [PWW-1:0] pm_s2 [6];
	logic signed [QWW-1:0] qm_s2 [6];
	logic signed [DW-1:0]  e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [C-1:0]   d_s2 [3], o_s2 [3];
	logic signed [2*C+1:0] dn_sum;

	assign dn_sum = (2*C+2)'(dn_s1[0]) + (2*C+2)'(dn_s1[1]) + (2*C+2)'(dn_s1[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pm_s2[2*j]   <= PWW'(d_s1[(j+1)%3]) * PWW'(e2_s1[(j+2)%3]);
				pm_s2[2*j+1] <= PWW'(d_s1[(j+2)%3]) * PWW'(e2_s1[(j+1)%3]);
				qm_s2[2*j]   <= QWW'(s_s1[(j+1)%3]) * QWW'(e1_s1[(j+2)%3]);
				qm_s2[2*j+1] <= QWW'(s_s1[(j+2)%3]) * QWW'(e1_s1[(j+1)%3]);
				e1_s2[j] <= e1_s1[j];
				e2_s2[j] <= e2_s1[j];
				s_s2[j]  <= s_s1[j];
				d_s2[j]  <= d_s1[j];
				o_s2[j]  <= o_s1[j];
			end
			cull_s2 <= cull_q && (dn_sum > 0);
		end
	end

	// S3: P = D x E2, Q = S x E1
	logic                  v_s3, cull_s3;
	logic signed [PWW-1:0] p_s3 [3];
	logic signed [QWW-1:0] q_s3 [3];
	logic signed [DW-1:0]  e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [C-1:0]   d_s3 [3], o_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				p_s3[j]  <= pm_s2[2*j] - pm_s2[2*j+1];
				q_s3[j]  <= qm_s2[2*j] - qm_s2[2*j+1];
				e1_s3[j] <= e1_s2[j];
				e2_s3[j] <= e2_s2[j];
				s_s3[j]  <= s_s2[j];
				d_s3[j]  <= d_s2[j];
				o_s3[j]  <= o_s2[j];
			end
			cull_s3 <= cull_s2;
		end
	end

	// S4: dot product terms
	logic                 v_s4, cull_s4;
	logic signed [MW-1:0] det_m_s4 [3], u_m_s4 [3], v_m_s4 [3], t_m_s4 [3];
	logic signed [C-1:0]  d_s4 [3], o_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				det_m_s4[j] <= MW'(e1_s3[j]) * MW'(p_s3[j]);
				u_m_s4[j]   <= MW'(s_s3[j])  * MW'(p_s3[j]);
				v_m_s4[j]   <= MW'(d_s3[j])  * MW'(q_s3[j]);
				t_m_s4[j]   <= MW'(e2_s3[j]) * MW'(q_s3[j]);
				d_s4[j]     <= d_s3[j];
				o_s4[j]     <= o_s3[j];
			end
			cull_s4 <= cull_s3;
		end
	end

	// S5: det and the three numerators
	logic                 v_s5, cull_s5;
	logic signed [NW-1:0] det_s5, nu_s5, nv_s5, nt_s5;
	logic signed [C-1:0]  d_s5 [3], o_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= NW'(det_m_s4[0]) + NW'(det_m_s4[1]) + NW'(det_m_s4[2]);
			nu_s5  <= NW'(u_m_s4[0]) + NW'(u_m_s4[1]) + NW'(u_m_s4[2]);
			nv_s5  <= NW'(v_m_s4[0]) + NW'(v_m_s4[1]) + NW'(v_m_s4[2]);
			nt_s5  <= NW'(t_m_s4[0]) + NW'(t_m_s4[1]) + NW'(t_m_s4[2]);
			for (int j = 0; j < 3; j++) begin
				d_s5[j] <= d_s4[j];
				o_s5[j] <= o_s4[j];
			end
			cull_s5 <= cull_s4;
		end
	end

	// S6: magnitudes, signs, parallel-ray check
	logic [NW-1:0]    dmag, umag, vmag, tmag_n;
	logic [EPS_W-1:0] det_floor;
	side_t            side_c;

	assign dmag      = det_s5[NW-1] ? NW'(-det_s5) : NW'(det_s5);
	assign umag      = nu_s5[NW-1]  ? NW'(-nu_s5)  : NW'(nu_s5);
	assign vmag      = nv_s5[NW-1]  ? NW'(-nv_s5)  : NW'(nv_s5);
	assign tmag_n    = nt_s5[NW-1]  ? NW'(-nt_s5)  : NW'(nt_s5);
	assign det_floor = (eps_q != '0) ? eps_q : EPS_W'(1);

	always_comb begin
		side_c.miss  = cull_s5 || (dmag < NW'(det_floor));
		side_c.neg_u = nu_s5[NW-1] ^ det_s5[NW-1];
		side_c.neg_v = nv_s5[NW-1] ^ det_s5[NW-1];
		side_c.neg_t = nt_s5[NW-1] ^ det_s5[NW-1];
		for (int j = 0; j < 3; j++) begin
			side_c.d[j] = d_s5[j];
			side_c.o[j] = o_s5[j];
		end
	end

	logic            v_s6;
	side_t           side_s6;
	logic [NW-1:0]   den_s6;
	logic [NUMW-1:0] nu_s6, nv_s6, nt_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_c;
			den_s6  <= dmag;
			nu_s6   <= {umag, OUT_FRAC'(0)};
			nv_s6   <= {vmag, OUT_FRAC'(0)};
			nt_s6   <= {tmag_n, OUT_FRAC'(0)};
		end
	end

	// dividers
	logic [QB-1:0] qu, qv, qt;
	logic          ovf_u, ovf_v, ovf_t;

	rti_div #(.NUM_W(NUMW), .DEN_W(NW), .QB(QB)) u_div_u (
		.clk(clk), .en(en), .num(nu_s6), .den(den_s6), .quot(qu), .ovf(ovf_u)
	);
	rti_div #(.NUM_W(NUMW), .DEN_W(NW), .QB(QB)) u_div_v (
		.clk(clk), .en(en), .num(nv_s6), .den(den_s6), .quot(qv), .ovf(ovf_v)
	);
	rti_div #(.NUM_W(NUMW), .DEN_W(NW), .QB(QB)) u_div_t (
		.clk(clk), .en(en), .num(nt_s6), .den(den_s6), .quot(qt), .ovf(ovf_t)
	);

	side_t side_dq [QB];
	logic  v_dq    [QB];

	always_ff @(posedge clk) begin
		if (en) begin
			side_dq[0] <= side_s6;
			for (int k = 1; k < QB; k++) side_dq[k] <= side_dq[k-1];
		end
	end

	// P1: saturate ratios, triangle and distance checks
	logic [BARY_W-1:0]        umag_c, vmag_c;
	logic signed [BARY_W-1:0] uq_c, vq_c;
	logic [DIST_W-1:0]        tq_c;
	logic signed [CHK-1:0]    eps_sx, one_eps;
	logic                     miss_c;
	side_t                    sd_o;

	assign sd_o    = side_dq[QB-1];
	assign eps_sx  = CHK'({1'b0, eps_q});
	assign one_eps = CHK'(ONE_Q16) + eps_sx;

	always_comb begin
		umag_c = (ovf_u || (qu > QB'(BARY_CAP))) ? BARY_CAP : qu[BARY_W-1:0];
		vmag_c = (ovf_v || (qv > QB'(BARY_CAP))) ? BARY_CAP : qv[BARY_W-1:0];
		uq_c   = sd_o.neg_u ? BARY_W'(-umag_c) : ((umag_c == BARY_CAP) ? BARY_MAX : umag_c);
		vq_c   = sd_o.neg_v ? BARY_W'(-vmag_c) : ((vmag_c == BARY_CAP) ? BARY_MAX : vmag_c);
		tq_c   = ovf_t ? '1 : qt[DIST_W-1:0];
		miss_c = sd_o.miss
			|| (CHK'(uq_c) < -eps_sx) || (CHK'(uq_c) > one_eps)
			|| (CHK'(vq_c) < -eps_sx) || ((CHK'(uq_c) + CHK'(vq_c)) > one_eps)
			|| sd_o.neg_t || (tq_c <= DIST_W'(eps_q));
	end

	logic                     v_p1, miss_p1;
	logic signed [BARY_W-1:0] uq_p1, vq_p1;
	logic [DIST_W-1:0]        tq_p1;
	logic [2:0][C-1:0]        d_p1, o_p1;

	always_ff @(posedge clk) begin
		if (en) begin
			miss_p1 <= miss_c;
			uq_p1   <= uq_c;
			vq_p1   <= vq_c;
			tq_p1   <= tq_c;
			d_p1    <= sd_o.d;
			o_p1    <= sd_o.o;
		end
	end

	// P2: direction times t
	logic                     v_p2, miss_p2;
	logic signed [BARY_W-1:0] uq_p2, vq_p2;
	logic [DIST_W-1:0]        tq_p2;
	logic signed [HPW-1:0]    prod_p2 [3];
	logic [2:0][C-1:0]        o_p2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				prod_p2[j] <= HPW'($signed(d_p1[j])) * HPW'($signed({1'b0, tq_p1}));
			end
			miss_p2 <= miss_p1;
			uq_p2   <= uq_p1;
			vq_p2   <= vq_p1;
			tq_p2   <= tq_p1;
			o_p2    <= o_p1;
		end
	end

	// P3: hit point, saturated per axis; zero everything on a miss
	logic signed [SW:0] sum_c [3];
	logic [WW-1:0]      pt_c;
	localparam logic signed [SW:0] CMAX = (SW+1)'((1 << (C - 1)) - 1);
	localparam logic signed [SW:0] CMIN = -(SW+1)'(1 << (C - 1));

	always_comb begin
		pt_c = '0;
		for (int j = 0; j < 3; j++) begin
			// the dropped low bits make this a floor of D*t
			sum_c[j] = (SW+1)'($signed(o_p2[j]))
				+ (SW+1)'($signed(prod_p2[j][HPW-1:OUT_FRAC]));
			if (sum_c[j] > CMAX) pt_c[j*C +: C] = CMAX[C-1:0];
			else if (sum_c[j] < CMIN) pt_c[j*C +: C] = CMIN[C-1:0];
			else pt_c[j*C +: C] = sum_c[j][C-1:0];
		end
	end

	logic                     v_p3, hit_p3;
	logic [DIST_W-1:0]        dist_p3;
	logic signed [BARY_W-1:0] u_p3, vv_p3;
	logic [PKT_W-1:0]         pt_p3;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_p3  <= !miss_p2;
			dist_p3 <= miss_p2 ? '0 : tq_p2;
			u_p3    <= miss_p2 ? '0 : uq_p2;
			vv_p3   <= miss_p2 ? '0 : vq_p2;
			pt_p3   <= miss_p2 ? '0 : pt_c[PKT_W-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < QB; k++) v_dq[k] <= 1'b0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_s1 <= tri_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_dq[0] <= v_s6;
			for (int k = 1; k < QB; k++) v_dq[k] <= v_dq[k-1];
			v_p1 <= v_dq[QB-1];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	// output skid: catches the last stage when the far side stalls
	logic                     hit_q;
	logic [DIST_W-1:0]        dist_q;
	logic signed [BARY_W-1:0] u_q, v_q;
	logic [PKT_W-1:0]         pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (!skid_full_q) begin
			skid_full_q <= v_p3 && res_stall;
		end else if (!res_stall) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			hit_q  <= hit_p3;
			dist_q <= dist_p3;
			u_q    <= u_p3;
			v_q    <= vv_p3;
			pt_q   <= pt_p3;
		end
	end

	assign res_valid = skid_full_q || v_p3;
	assign hit       = skid_full_q ? hit_q  : hit_p3;
	assign distance  = skid_full_q ? dist_q : dist_p3;
	assign bary_u    = skid_full_q ? u_q    : u_p3;
	assign bary_v    = skid_full_q ? v_q    : vv_p3;
	assign hit_point = skid_full_q ? pt_q   : pt_p3;
endmodule
`default_nettype wire
